FILE: hw/rtl/lrul_pkg.sv
// ----------------------------------------------------------------------------
// lrul_pkg
// Shared request, status and state codes plus controller/datapath bundles
// for the lru replacement list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lrul_pkg;

  typedef enum logic [1:0] {
    REQ_PUT    = 2'd0,
    REQ_GET    = 2'd1,
    REQ_OBTAIN = 2'd2,
    REQ_RESET  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_DUP    = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } fsm_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;  // capture request, launch link reads
    logic exec;  // apply update and fill result register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;  // result register empty or being drained this cycle
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lrul_if.sv
// ----------------------------------------------------------------------------
// lrul request / response channels
// Valid/ready channels carrying one list request and one list result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lrul_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [3:0] entry_index;

  modport source (output valid, output req_type, output entry_index, input ready);
  modport sink   (input valid, input req_type, input entry_index, output ready);
endinterface

interface lrul_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] victim_index;
  logic       victim_valid;
  logic       list_empty;
  logic [1:0] status;

  modport source (output valid, output victim_index, output victim_valid,
                  output list_empty, output status, input ready);
  modport sink   (input valid, input victim_index, input victim_valid,
                  input list_empty, input status, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/lru_replacement_list.sv
// a request accepted in S_IDLE has its link reads registered, then S_EXEC applies
//   the update and fills the result register; no new request is taken during
//   S_EXEC, as the link memories are read into registers ahead of the update step
// the result register lets the next request enter in the cycle the result drains
// reset: synchronous active-low rst_n empties the list and drops out valid;
//   link memories are not cleared and need no reset pass
// ----------------------------------------------------------------------------
// lru_replacement_list
// Recency-ordered list of reclaimable cache entries: put, get, obtain-oldest
// and reset requests over a doubly linked list kept in two link memories.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lru_replacement_list
  import lrul_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  lrul_req_if.sink   in_req,
  lrul_rsp_if.source out_rsp
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  lrul_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lrul_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_req_type      (in_req.req_type),
    .in_entry_index   (in_req.entry_index),
    .out_valid        (out_rsp.valid),
    .out_ready        (out_rsp.ready),
    .out_victim_index (out_rsp.victim_index),
    .out_victim_valid (out_rsp.victim_valid),
    .out_list_empty   (out_rsp.list_empty),
    .out_status       (out_rsp.status)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/lrul_ctrl.sv
// ----------------------------------------------------------------------------
// lrul_ctrl
// Two-state sequencer: accept a request and launch link reads, then apply
// the list update and post the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrul_ctrl
  import lrul_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  fsm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        // only take a transaction when the result slot will be free
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.exec)
    else $error("load not followed by exec");

  a_exec_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> $past(cmd.load))
    else $error("exec without preceding load");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !in_ready)
    else $error("ready raised while a request is in flight");

endmodule

`default_nettype wire

FILE: hw/rtl/lrul_dp.sv
// ----------------------------------------------------------------------------
// lrul_dp
// List state (membership bits, end pointers, count), link memories and the
// result register of the lru replacement list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrul_dp
  import lrul_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire dp_cmd_t    cmd,
  output dp_sts_t         sts,
  input  wire logic [1:0] in_req_type,
  input  wire logic [3:0] in_entry_index,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [3:0]      out_victim_index,
  output logic            out_victim_valid,
  output logic            out_list_empty,
  output logic [1:0]      out_status
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  // list state
  logic [ENTRIES-1:0] listed_r, listed_nxt;
  logic [IW-1:0]      newest_r, newest_nxt;
  logic [IW-1:0]      oldest_r, oldest_nxt;
  logic [CW-1:0]      count_r, count_nxt;

  // captured request
  req_t       req_r;
  logic [3:0] idx_r;

  // link memories
  logic [IW-1:0] older_mem [ENTRIES];
  logic [IW-1:0] newer_mem [ENTRIES];
  logic [IW-1:0] older_rd_r, newer_rd_r;
  logic [IW-1:0] rd_addr;
  logic          older_we, newer_we;
  logic [IW-1:0] older_wa, older_wd, newer_wa, newer_wd;

  // result register
  logic       out_valid_r;
  logic [3:0] victim_r;
  logic       vvalid_r;
  logic       empty_r;
  status_t    status_r;

  // combinational update
  logic [IW-1:0] tgt;
  logic          in_range;
  logic          do_link, do_unlink, do_clear;
  status_t       status_c;
  logic          vvalid_c;

  assign rd_addr = (req_t'(in_req_type) == REQ_OBTAIN) ? oldest_r : IW'(in_entry_index);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= req_t'(in_req_type);
      idx_r <= in_entry_index;
    end
  end

  always_ff @(posedge clk) begin
    if (older_we) older_mem[older_wa] <= older_wd;
    if (cmd.load) older_rd_r <= older_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (newer_we) newer_mem[newer_wa] <= newer_wd;
    if (cmd.load) newer_rd_r <= newer_mem[rd_addr];
  end

  always_comb begin
    listed_nxt = listed_r;
    newest_nxt = newest_r;
    oldest_nxt = oldest_r;
    count_nxt  = count_r;
    older_we   = 1'b0;
    older_wa   = '0;
    older_wd   = '0;
    newer_we   = 1'b0;
    newer_wa   = '0;
    newer_wd   = '0;
    do_link    = 1'b0;
    do_unlink  = 1'b0;
    do_clear   = 1'b0;
    status_c   = ST_OK;
    vvalid_c   = 1'b0;
    in_range   = 32'(idx_r) < ENTRIES;
    tgt        = (req_r == REQ_OBTAIN) ? oldest_r : IW'(idx_r);

    if (cmd.exec) begin
      unique case (req_r)
        REQ_PUT: begin
          priority if (!in_range)  status_c = ST_ABSENT;
          else if (listed_r[tgt])  status_c = ST_DUP;
          else                     do_link  = 1'b1;
        end
        REQ_GET: begin
          if (!in_range || !listed_r[tgt]) status_c  = ST_ABSENT;
          else                             do_unlink = 1'b1;
        end
        REQ_OBTAIN: begin
          if (count_r == '0) begin
            status_c = ST_EMPTY;
          end else begin
            do_unlink = 1'b1;
            vvalid_c  = 1'b1;
          end
        end
        REQ_RESET: begin
          do_clear = 1'b1;
        end
        default: begin
          do_clear = 1'b1;
        end
      endcase
    end

    if (do_link) begin
      if (count_r == '0) begin
        oldest_nxt = tgt;
      end else begin
        older_we = 1'b1;
        older_wa = tgt;
        older_wd = newest_r;
        newer_we = 1'b1;
        newer_wa = newest_r;
        newer_wd = tgt;
      end
      newest_nxt      = tgt;
      listed_nxt[tgt] = 1'b1;
      count_nxt       = count_r + CW'(1);
    end

    if (do_unlink) begin
      // older_rd_r / newer_rd_r hold the links of tgt, read at accept
      priority if (count_r <= CW'(1)) begin
        newest_nxt = '0;
        oldest_nxt = '0;
      end else if (tgt == oldest_r) begin
        oldest_nxt = newer_rd_r;
      end else if (tgt == newest_r) begin
        newest_nxt = older_rd_r;
      end else begin
        newer_we = 1'b1;
        newer_wa = older_rd_r;
        newer_wd = newer_rd_r;
        older_we = 1'b1;
        older_wa = newer_rd_r;
        older_wd = older_rd_r;
      end
      listed_nxt[tgt] = 1'b0;
      count_nxt       = count_r - CW'(1);
    end

    if (do_clear) begin
      listed_nxt = '0;
      newest_nxt = '0;
      oldest_nxt = '0;
      count_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      listed_r <= '0;
      newest_r <= '0;
      oldest_r <= '0;
      count_r  <= '0;
    end else begin
      listed_r <= listed_nxt;
      newest_r <= newest_nxt;
      oldest_r <= oldest_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      victim_r <= vvalid_c ? 4'(oldest_r) : 4'd0;
      vvalid_r <= vvalid_c;
      empty_r  <= (count_nxt == '0);
      status_r <= status_c;
    end
  end

  assign sts.out_free     = !out_valid_r || out_ready;
  assign out_valid        = out_valid_r;
  assign out_victim_index = victim_r;
  assign out_victim_valid = vvalid_r;
  assign out_list_empty   = empty_r;
  assign out_status       = status_r;

  a_count_matches_listed: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(listed_r) == 32'(count_r))
    else $error("member count out of step with membership bits");

  a_empty_ends_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (newest_r == '0 && oldest_r == '0))
    else $error("end pointers not cleared on empty list");

  a_ends_listed: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> (listed_r[newest_r] && listed_r[oldest_r]))
    else $error("list end points at an unlisted entry");

  a_victim_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && vvalid_r) |-> (status_r == ST_OK && !$isunknown(victim_r)))
    else $error("victim reported with error status");

  a_exec_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid_r)
    else $error("result register not filled after exec");

endmodule

`default_nettype wire
